/* rtl/vertex_project_line_strip_defines.svh */
// Assertion helpers for the vertex projection block.
`ifndef VERTEX_PROJECT_LINE_STRIP_DEFINES_SVH
`define VERTEX_PROJECT_LINE_STRIP_DEFINES_SVH

`ifndef SYNTHESIS

`define VPLS_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

`define VPLS_ASSERT(lbl, prop, msg) \
  `VPLS_ASSERT_CLK(lbl, clk, rst, prop, msg)

`else

`define VPLS_ASSERT_CLK(lbl, ck, rs, prop, msg)

`define VPLS_ASSERT(lbl, prop, msg)

`endif

`endif

/* rtl/vpls_pkg.sv */
package vpls_pkg;

  localparam int COEF_W = 16;
  localparam int OPND_W = 33;
  localparam int PROD_W = COEF_W + OPND_W;
  localparam int ACC_W  = 50;
  localparam int HALF_W = 12;
  localparam int NUM_W  = ACC_W + 13;
  localparam int CMP_W  = ACC_W + 16;
  localparam int PIX_W  = 16;

  localparam logic [2:0] CFG_ROW0   = 3'd0;
  localparam logic [2:0] CFG_HALF_W = 3'd4;
  localparam logic [2:0] CFG_HALF_H = 3'd5;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               first_of_strip;
  } vert_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] from_x;
    logic signed [PIX_W-1:0] from_y;
    logic signed [PIX_W-1:0] to_x;
    logic signed [PIX_W-1:0] to_y;
    logic                    draw;
    logic                    w_zero;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_WCHK,
    ST_HMUL,
    ST_DCHK,
    ST_DIV,
    ST_SAT,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

/* rtl/vertex_project_line_strip.sv */
// Projects line-strip vertices through a 4x4 matrix and emits one segment per
// vertex. One vertex is taken at a time: the matrix runs on the shared 16x33
// multiplier, then each pixel coordinate gets a shift-add multiply (half
// viewport times w) and the restoring divider; when first_of_strip is set the
// origin is projected first. A zero w skips the shift-add and the divider. The
// vertex port stalls while an item is at work; the finished segment sits in an
// output register, so the next vertex transfers while it waits.
`include "vertex_project_line_strip_defines.svh"
module vertex_project_line_strip
  import vpls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        vert_valid,
  output logic        vert_stall,
  input  vert_t       vert,
  output logic        seg_valid,
  input  logic        seg_stall,
  output seg_t        seg,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state, state_next;

  logic [63:0]             mrow [4];
  logic [HALF_W-1:0]       hw, hh;
  logic signed [PIX_W-1:0] prev_x, prev_y;

  vert_t                   cur;
  logic                    pass;
  logic [3:0]              mac_i;
  logic signed [ACC_W-1:0] acc [4];
  logic                    coord;
  logic [3:0]              hcnt;
  logic signed [NUM_W-1:0] n, ws;
  logic                    neg, ovf;
  logic [CMP_W-1:0]        r, ds;
  logic [PIX_W-1:0]        q;
  logic [3:0]              dcnt;
  logic signed [PIX_W-1:0] px, py, fx, fy;
  logic                    wz;

  // multiplier operand and product
  logic [1:0]               row, col;
  logic signed [COEF_W-1:0] coef;
  logic signed [OPND_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_x;

  assign row  = mac_i[3:2];
  assign col  = mac_i[1:0];
  assign coef = mrow[row][16*col +: COEF_W];

  always_comb begin
    unique case (col)
      2'd0:    opnd = pass ? OPND_W'(cur.vert_x) : '0;
      2'd1:    opnd = pass ? OPND_W'(cur.vert_y) : '0;
      2'd2:    opnd = pass ? OPND_W'(cur.vert_z) : '0;
      default: opnd = OPND_W'(65536);
    endcase
  end

  assign prod   = coef * opnd;
  assign prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  logic                    hbit;
  logic [NUM_W-1:0]        n_mag;
  logic [ACC_W-1:0]        w_mag, z_mag;
  logic [CMP_W-1:0]        d_top;
  logic signed [PIX_W-1:0] sat;
  logic                    vis;

  assign hbit  = coord ? hh[hcnt] : hw[hcnt];
  assign n_mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
  assign w_mag = acc[3][ACC_W-1] ? ACC_W'(-acc[3]) : ACC_W'(acc[3]);
  assign z_mag = acc[2][ACC_W-1] ? ACC_W'(-acc[2]) : ACC_W'(acc[2]);
  assign d_top = {w_mag, 16'b0};
  assign vis   = !wz && (z_mag <= w_mag);

  always_comb begin
    if (neg) begin
      sat = (ovf || q > 16'd32768) ? 16'sh8000 : PIX_W'(-q);
    end else begin
      sat = (ovf || q[PIX_W-1]) ? 16'sh7fff : PIX_W'(q);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (vert_valid) state_next = ST_MAC;
      ST_MAC:  if (mac_i == 4'd15) state_next = ST_WCHK;
      ST_WCHK: state_next = (acc[3] == '0) ? ST_FIN : ST_HMUL;
      ST_HMUL: if (hcnt == 4'(HALF_W-1)) state_next = ST_DCHK;
      ST_DCHK: state_next = ST_DIV;
      ST_DIV:  if (dcnt == 4'd15) state_next = ST_SAT;
      ST_SAT:  state_next = coord ? ST_FIN : ST_HMUL;
      ST_FIN:  state_next = pass ? ST_OUT : ST_MAC;
      ST_OUT:  if (!(seg_valid && seg_stall)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    vert_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_valid <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      hw        <= '0;
      hh        <= '0;
      for (int i = 0; i < 4; i++) mrow[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && !(seg_valid && seg_stall)) seg_valid <= 1'b1;
      else if (seg_valid && !seg_stall) seg_valid <= 1'b0;

      if (cfg_we) begin
        if (cfg_index < CFG_HALF_W) mrow[cfg_index[1:0] - CFG_ROW0[1:0]] <= cfg_data;
        else if (cfg_index == CFG_HALF_W) hw <= cfg_data[HALF_W-1:0];
        else if (cfg_index == CFG_HALF_H) hh <= cfg_data[HALF_W-1:0];
      end

      unique case (state)
        ST_IDLE: begin
          if (vert_valid) begin
            cur   <= vert;
            pass  <= !vert.first_of_strip;
            mac_i <= '0;
          end
        end
        ST_MAC: begin
          acc[row] <= ((col == 2'd0) ? '0 : acc[row]) + prod_x;
          mac_i    <= mac_i + 4'd1;
        end
        ST_WCHK: begin
          wz    <= (acc[3] == '0);
          px    <= PIX_W'(hw);
          py    <= PIX_W'(hh);
          coord <= 1'b0;
          hcnt  <= '0;
          n     <= NUM_W'(acc[0]);
          ws    <= NUM_W'(acc[3]);
        end
        ST_HMUL: begin
          if (hbit) n <= n + ws;
          ws   <= ws <<< 1;
          hcnt <= hcnt + 4'd1;
        end
        ST_DCHK: begin
          neg  <= n[NUM_W-1] ^ acc[3][ACC_W-1];
          r    <= CMP_W'(n_mag);
          ovf  <= CMP_W'(n_mag) >= d_top;
          ds   <= d_top >> 1;
          q    <= '0;
          dcnt <= '0;
        end
        ST_DIV: begin
          if (r >= ds) begin
            r <= r - ds;
            q <= {q[PIX_W-2:0], 1'b1};
          end else begin
            q <= {q[PIX_W-2:0], 1'b0};
          end
          ds   <= ds >> 1;
          dcnt <= dcnt + 4'd1;
        end
        ST_SAT: begin
          if (coord) py <= sat;
          else px <= sat;
          coord <= 1'b1;
          hcnt  <= '0;
          n     <= NUM_W'(acc[1]);
          ws    <= NUM_W'(acc[3]);
        end
        ST_FIN: begin
          if (!pass) begin
            fx    <= px;
            fy    <= py;
            pass  <= 1'b1;
            mac_i <= '0;
          end
        end
        ST_OUT: begin
          if (!(seg_valid && seg_stall)) begin
            seg.from_x  <= cur.first_of_strip ? fx : prev_x;
            seg.from_y  <= cur.first_of_strip ? fy : prev_y;
            seg.to_x    <= px;
            seg.to_y    <= py;
            seg.draw    <= vis;
            seg.w_zero  <= wz;
            prev_x      <= px;
            prev_y      <= py;
          end
        end
        default: ;
      endcase
    end
  end

  `VPLS_ASSERT(a_accept_starts, vert_valid && !vert_stall |=> state == ST_MAC, "no start")
  `VPLS_ASSERT(a_out_issue, state == ST_OUT && !(seg_valid && seg_stall) |=> seg_valid, "issue")
  `VPLS_ASSERT(a_wzero_nodraw, seg_valid |-> !(seg.w_zero && seg.draw), "draw with zero w")
  `VPLS_ASSERT(a_div_count, state == ST_SAT |-> $past(dcnt) == 4'd15, "divider cut short")

endmodule

/* tb/tb_vertex_project_line_strip.sv */
`timescale 1ns / 100ps
module tb_vertex_project_line_strip;
  import vpls_pkg::*;

  localparam logic [2:0] CFG_SPARE = 3'd6;  // no register behind this index
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        vert_valid = 1'b0;
  logic        vert_stall;
  vert_t       vert = '0;
  logic        seg_valid;
  logic        seg_stall = 1'b0;
  seg_t        seg;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // predictor copy of the registers and last point
  logic [63:0]        mat_rows [4];
  logic [11:0]        half_x;
  logic [11:0]        half_y;
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;

  seg_t segs_pending [$];
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_wzero = 0;
  int   n_drawn = 0;
  int   n_sent = 0;
  int   cycles = 0;
  int   hold_left = 0;
  int   burst_left = 0;
  bit   rx_quiet = 1'b0;
  bit   tx_quiet = 1'b0;

  vertex_project_line_strip u_top (
    .clk(clk), .rst(rst),
    .vert_valid(vert_valid), .vert_stall(vert_stall), .vert(vert),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding", cycles,
               segs_pending.size());
      $display("vertex_project_line_strip test failed");
      $finish;
    end
  end

  function automatic longint row_sum(int r, logic signed [31:0] x, logic signed [31:0] y,
                                     logic signed [31:0] z);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(mat_rows[r][15:0]));
    c1 = longint'($signed(mat_rows[r][31:16]));
    c2 = longint'($signed(mat_rows[r][47:32]));
    c3 = longint'($signed(mat_rows[r][63:48]));
    return c0 * longint'(x) + c1 * longint'(y) + c2 * longint'(z) + c3 * 65536;
  endfunction

  function automatic logic signed [15:0] to_pixel(longint a, longint w, logic [11:0] h);
    longint q;
    q = (a + longint'({1'b0, h}) * w) / w;
    if (q > 32767) return 16'sh7fff;
    if (q < -32768) return 16'sh8000;
    return q[15:0];
  endfunction

  function automatic void project_point(input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z,
                                        output logic signed [15:0] px,
                                        output logic signed [15:0] py, output logic wz,
                                        output logic vis);
    longint sx, sy, sz, sw;
    sx = row_sum(0, x, y, z);
    sy = row_sum(1, x, y, z);
    sz = row_sum(2, x, y, z);
    sw = row_sum(3, x, y, z);
    if (sw == 0) begin
      px = {4'b0, half_x};
      py = {4'b0, half_y};
      wz = 1'b1;
      vis = 1'b0;
    end else begin
      px = to_pixel(sx, sw, half_x);
      py = to_pixel(sy, sw, half_y);
      wz = 1'b0;
      vis = ((sz < 0) ? -sz : sz) <= ((sw < 0) ? -sw : sw);
    end
  endfunction

  function automatic seg_t predict_segment(vert_t v);
    seg_t s;
    logic wz, vis;
    s.from_x = last_x;
    s.from_y = last_y;
    if (v.first_of_strip)
      project_point(32'sd0, 32'sd0, 32'sd0, s.from_x, s.from_y, wz, vis);
    project_point(v.vert_x, v.vert_y, v.vert_z, s.to_x, s.to_y, s.w_zero, s.draw);
    last_x = s.to_x;
    last_y = s.to_y;
    return s;
  endfunction

  // result side: check each transfer, then choose the next stall
  always @(posedge clk) begin
    if (!rst && seg_valid && !seg_stall) begin
      if (segs_pending.size() == 0) begin
        $display("%0t: unexpected segment %p", $time, seg);
        n_errors++;
      end else begin
        seg_t exp_seg;
        exp_seg = segs_pending.pop_front();
        n_checked++;
        if (exp_seg.w_zero) n_wzero++;
        if (exp_seg.draw) n_drawn++;
        if (seg.from_x !== exp_seg.from_x || seg.from_y !== exp_seg.from_y ||
            seg.to_x !== exp_seg.to_x || seg.to_y !== exp_seg.to_y ||
            seg.draw !== exp_seg.draw || seg.w_zero !== exp_seg.w_zero) begin
          $display("%0t: segment mismatch expected %p actual %p", $time, exp_seg, seg);
          n_errors++;
        end
      end
    end
    if (hold_left > 0) begin
      seg_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (burst_left > 0) begin
      seg_stall <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (rx_quiet || $urandom_range(0, 4) != 0) begin
      seg_stall <= 1'b0;
    end else begin
      seg_stall <= 1'b1;
      burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                               : $urandom_range(0, 3);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < CFG_HALF_W) mat_rows[idx[1:0]] = data;
    else if (idx == CFG_HALF_W) half_x = data[11:0];
    else if (idx == CFG_HALF_H) half_y = data[11:0];
  endtask

  task automatic load_config(logic [63:0] rows [4], logic [63:0] hx, logic [63:0] hy);
    for (int r = 0; r < 4; r++)
      write_reg(CFG_ROW0 + 3'(r), rows[r]);
    write_reg(CFG_HALF_W, hx);
    write_reg(CFG_HALF_H, hy);
    write_reg(CFG_SPARE, {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_vertex(vert_t v);
    int gap;
    gap = 0;
    if (!tx_quiet && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 250) : $urandom_range(1, 4);
    if (gap > 0) begin
      vert_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    segs_pending.insert(segs_pending.size(), predict_segment(v));
    n_sent++;
    vert <= v;
    vert_valid <= 1'b1;
    do @(posedge clk); while (vert_stall);
  endtask

  task automatic drain;
    vert_valid <= 1'b0;
    while (segs_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'($signed($urandom_range(0, 16'h2000)) - 32'sh1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      2, 3: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vert_t rand_vertex(bit start);
    vert_t v;
    v.vert_x = rand_coord();
    v.vert_y = rand_coord();
    v.vert_z = rand_coord();
    v.first_of_strip = start;
    return v;
  endfunction

  // reset values: all-zero matrix, so every w is zero
  task automatic test_reset_state;
    vert_t v;
    v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, 1'b0};
    send_vertex(v);
    v = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 1'b1};
    send_vertex(v);
    drain();
  endtask

  task automatic test_directed;
    logic [63:0] rows [4];
    vert_t v;
    // identity with w = z plus one: clean perspective
    rows = '{64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
             64'h0000_1000_0000_0000, 64'h1000_1000_0000_0000};
    load_config(rows, 64'd4095, 64'd0);
    v = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0000_0000, 1'b1};
    send_vertex(v);
    v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_8000, 1'b0};
    send_vertex(v);
    // z = -1 makes w zero on the new point
    v = '{32'sh0003_0000, 32'sh0004_0000, 32'shffff_0000, 1'b0};
    send_vertex(v);
    v = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0};
    send_vertex(v);
    v = '{32'shffff_ffff, 32'sh0000_0001, 32'shfffe_0000, 1'b1};
    send_vertex(v);
    drain();
    // zero w at the origin; extreme coefficients, saturating pixels
    rows = '{64'h8000_7fff_8000_7fff, 64'h7fff_8000_7fff_8000,
             64'h8000_8000_8000_8000, 64'h0000_0001_0001_0001};
    load_config(rows, 64'hffff_ffff_ffff_f000, 64'd4095);
    v = '{32'sh0000_0001, 32'sh0, 32'sh0, 1'b1};
    send_vertex(v);
    v = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1};
    send_vertex(v);
    v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0};
    send_vertex(v);
    v = '{32'sh0, 32'sh0, 32'sh0, 1'b0};
    send_vertex(v);
    drain();
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    logic [63:0] rows [4];
    logic [63:0] hx, hy;
    for (int p = 0; p < phases; p++) begin
      for (int r = 0; r < 3; r++)
        rows[r] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      if (p % 3 == 0)
        rows[3] = {rand_coef(), rand_coef(), 16'h0, 16'h0};  // w from z and constant
      else
        rows[3] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      case (p % 4)
        0: begin hx = '0; hy = 64'd4095; end
        1: begin hx = 64'd4095; hy = '0; end
        default: begin hx = {$urandom, $urandom}; hy = {$urandom, $urandom}; end
      endcase
      load_config(rows, hx, hy);
      rx_quiet = (p % 5 == 4);
      tx_quiet = (p % 5 == 3);
      for (int i = 0; i < per_phase; i++)
        send_vertex(rand_vertex($urandom_range(0, 7) == 0));
      drain();
    end
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
  endtask

  // receiver holds off while vertices keep coming, so the input backs up
  task automatic test_backpressure;
    tx_quiet = 1'b1;
    hold_left = 2000;
    for (int i = 0; i < 30; i++)
      send_vertex(rand_vertex(i % 10 == 0));
    tx_quiet = 1'b0;
    drain();
  endtask

  initial begin
    mat_rows = '{default: '0};
    half_x = '0;
    half_y = '0;
    last_x = '0;
    last_y = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random_phases(6, 300);
    test_backpressure();
    $display("%0d vertices sent, %0d segments checked (%0d with zero w, %0d drawable)",
             n_sent, n_checked, n_wzero, n_drawn);
    $display("covered reset state, extreme inputs and coefficients, strip starts, stalls");
    if (n_errors == 0 && segs_pending.size() == 0) begin
      $display("vertex_project_line_strip test passed");
    end else begin
      $display("%0d mismatches, %0d segments missing", n_errors, segs_pending.size());
      $display("vertex_project_line_strip test failed");
    end
    $finish;
  end

endmodule
